// ----- sv/set_associative_depth_replace_table_assert.svh -----
// Assertion macros shared by the position cache RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef SET_ASSOCIATIVE_DEPTH_REPLACE_TABLE_ASSERT_SVH
`define SET_ASSOCIATIVE_DEPTH_REPLACE_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SADRT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SADRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sadrt_pkg.sv -----
// Package for the set-associative position cache: types, codes and constants.
// Used by sadrt_match, sadrt_victim, the top level and the testbench; depends on nothing.
package sadrt_pkg;

  localparam int DEF_SET_BITS = 12;
  localparam int DEF_WAYS     = 4;
  localparam int WAY_IDX_MAX  = 4;
  localparam int KEY_W        = 64;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic [1:0] MODE_PROBE = 2'd0;
  localparam logic [1:0] MODE_SAVE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  typedef struct packed {
    logic [15:0]        move;
    logic [1:0]         kind;
    logic [7:0]         depth;
    logic signed [31:0] score;
  } payload_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] tag;
    payload_t         payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                   hit;
    payload_t               hit_data;
    logic                   found;
    logic                   found_write;
    logic [WAY_IDX_MAX-1:0] found_way;
  } match_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOK
  } state_t;

  function automatic logic [15:0] lfsr_step(logic [15:0] s);
    logic [15:0] shifted;
    shifted = s >> 1;
    return s[0] ? (shifted ^ LFSR_TAPS) : shifted;
  endfunction

  // Residue of each bit weight 2**i modulo the way count.
  function automatic logic [15:0][WAY_IDX_MAX-1:0] bit_residues(int ways);
    logic [15:0][WAY_IDX_MAX-1:0] r;
    int p;
    p = (ways > 1) ? 1 : 0;
    for (int i = 0; i < 16; i++) begin
      r[i] = WAY_IDX_MAX'(p);
      p = p * 2;
      if (p >= ways) begin
        p = p - ways;
      end
    end
    return r;
  endfunction

  // Residue of every 8-bit value modulo the way count.
  function automatic logic [255:0][WAY_IDX_MAX-1:0] residue_table(int ways);
    logic [255:0][WAY_IDX_MAX-1:0] t;
    int r;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      t[i] = WAY_IDX_MAX'(r);
      r = r + 1;
      if (r >= ways) begin
        r = 0;
      end
    end
    return t;
  endfunction

endpackage

// ----- sv/sadrt_ram.sv -----
// Single-port-write, single-port-read synchronous row memory of the position cache.
// Read data is registered; depends on nothing.
module sadrt_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/sadrt_match.sv -----
// Way comparison for one set row: probe hit and save placement.
// Depends on sadrt_pkg.
module sadrt_match #(
  parameter int WAYS = sadrt_pkg::DEF_WAYS
) (
  input  sadrt_pkg::entry_t [WAYS-1:0]       row,
  input  logic [sadrt_pkg::KEY_W-1:0]        key,
  input  logic [7:0]                         depth,
  output sadrt_pkg::match_t                  result
);

  logic [WAYS-1:0] key_hit;
  logic [WAYS-1:0] placeable;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      key_hit[w]   = row[w].valid && (row[w].tag == key);
      placeable[w] = !row[w].valid || (row[w].tag == key);
    end
  end

  always_comb begin
    result = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (key_hit[w]) begin
        result.hit      = 1'b1;
        result.hit_data = row[w].payload;
      end
      if (placeable[w]) begin
        result.found       = 1'b1;
        result.found_way   = sadrt_pkg::WAY_IDX_MAX'(w);
        result.found_write = !row[w].valid || (row[w].payload.depth < depth);
      end
    end
  end

endmodule

// ----- sv/sadrt_victim.sv -----
// Galois LFSR that picks the replacement way, with its residue precomputed.
// Depends on sadrt_pkg.
module sadrt_victim #(
  parameter int WAYS = sadrt_pkg::DEF_WAYS,
  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  output logic [WAY_BITS-1:0] victim
);

  localparam logic [15:0][sadrt_pkg::WAY_IDX_MAX-1:0] WEIGHTS =
    sadrt_pkg::bit_residues(WAYS);
  localparam logic [255:0][sadrt_pkg::WAY_IDX_MAX-1:0] RESIDUES =
    sadrt_pkg::residue_table(WAYS);

  logic [15:0] lfsr;
  logic [15:0] lfsr_adv;
  logic [7:0]  weight_sum;

  assign lfsr_adv = sadrt_pkg::lfsr_step(lfsr);

  always_comb begin
    weight_sum = '0;
    for (int i = 0; i < 16; i++) begin
      if (lfsr_adv[i]) begin
        weight_sum = weight_sum + 8'(WEIGHTS[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= sadrt_pkg::LFSR_SEED;
    end else if (advance) begin
      lfsr <= lfsr_adv;
    end
  end

  // The residue of the next LFSR value is registered from the LFSR register after each step.
  always_ff @(posedge clk) begin
    victim <= WAY_BITS'(RESIDUES[weight_sum]);
  end

endmodule

// ----- sv/set_associative_depth_replace_table.sv -----
// Top level of the set-associative position cache with depth-preferred replacement.
// Depends on sadrt_pkg, sadrt_ram, sadrt_match, sadrt_victim and the assertion header.
//
//   Channel  Handshake           Payload
//   input    in_valid/in_ready   mode, position_key, score_in, depth_in, move_in, node_kind_in
//   output   out_valid/out_ready hit, score_out, depth_out, move_out, node_kind_out,
//                                evicted_random, overwrite_total
//
// For a probe, save or no-op, the set row is read at the transfer and registered by the RAM;
// in the compare state the row is compared, and a save that changes a way writes it back as the result is issued.
// A clear then runs the row sweep, which writes one set per cycle.
// After reset the same sweep runs over every set before the first transfer.
// A stalled output holds the compare cycle; a new item is taken while a result waits.
`include "set_associative_depth_replace_table_assert.svh"

module set_associative_depth_replace_table #(
  parameter int SET_BITS = sadrt_pkg::DEF_SET_BITS,
  parameter int WAYS     = sadrt_pkg::DEF_WAYS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [63:0]        position_key,
  input  logic signed [31:0] score_in,
  input  logic [7:0]         depth_in,
  input  logic [15:0]        move_in,
  input  logic [1:0]         node_kind_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic signed [31:0] score_out,
  output logic [7:0]         depth_out,
  output logic [15:0]        move_out,
  output logic [1:0]         node_kind_out,
  output logic               evicted_random,
  output logic [31:0]        overwrite_total
);

  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W    = WAYS * sadrt_pkg::ENTRY_W;

  sadrt_pkg::state_t state;
  sadrt_pkg::state_t state_next;

  logic [SET_BITS-1:0] sweep_idx;
  logic [1:0]          mode_q;
  logic [63:0]         key_q;
  sadrt_pkg::payload_t payload_q;
  logic [31:0]         cnt;
  logic [31:0]         cnt_next;

  logic                ram_rd_en;
  logic [ROW_W-1:0]    ram_rd_data;
  logic                ram_wr_en;
  logic [SET_BITS-1:0] ram_wr_addr;
  logic [ROW_W-1:0]    ram_wr_data;

  sadrt_pkg::entry_t [WAYS-1:0] rd_row;
  sadrt_pkg::entry_t [WAYS-1:0] new_row;
  sadrt_pkg::match_t            m;
  logic [WAY_BITS-1:0]          victim;
  logic [WAY_BITS-1:0]          put_way;

  logic go;
  logic evict;
  logic is_save;
  logic save_write;

  logic               hit_next;
  sadrt_pkg::payload_t data_next;

  assign rd_row = ram_rd_data;

  sadrt_ram #(
    .ADDR_W (SET_BITS),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (position_key[SET_BITS-1:0]),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  sadrt_match #(
    .WAYS (WAYS)
  ) u_match (
    .row    (rd_row),
    .key    (key_q),
    .depth  (payload_q.depth),
    .result (m)
  );

  sadrt_victim #(
    .WAYS (WAYS)
  ) u_victim (
    .clk     (clk),
    .rst     (rst),
    .advance (evict),
    .victim  (victim)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      sadrt_pkg::ST_SWEEP: begin
        if (sweep_idx == '1) begin
          state_next = sadrt_pkg::ST_IDLE;
        end
      end
      sadrt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = sadrt_pkg::ST_LOOK;
        end
      end
      sadrt_pkg::ST_LOOK: begin
        if (go) begin
          state_next = (mode_q == sadrt_pkg::MODE_CLEAR) ? sadrt_pkg::ST_SWEEP
                                                         : sadrt_pkg::ST_IDLE;
        end
      end
      default: state_next = sadrt_pkg::ST_SWEEP;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    go         = 1'b0;
    ram_wr_en  = 1'b0;
    is_save    = (mode_q == sadrt_pkg::MODE_SAVE);
    save_write = 1'b0;
    evict      = 1'b0;
    hit_next   = 1'b0;
    data_next  = '0;
    unique case (state)
      sadrt_pkg::ST_SWEEP: begin
        ram_wr_en = 1'b1;
      end
      sadrt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      sadrt_pkg::ST_LOOK: begin
        go = !out_valid || out_ready;
        unique case (mode_q)
          sadrt_pkg::MODE_PROBE: begin
            hit_next  = m.hit;
            data_next = m.hit ? m.hit_data : '0;
          end
          sadrt_pkg::MODE_SAVE: begin
            evict      = go && !m.found;
            save_write = !m.found || m.found_write;
          end
          sadrt_pkg::MODE_CLEAR, sadrt_pkg::MODE_NOP: begin
          end
          default: begin
          end
        endcase
        ram_wr_en = go && is_save && save_write;
      end
      default: begin
      end
    endcase
  end

  assign ram_rd_en = in_valid && in_ready;
  assign cnt_next  = evict ? cnt + 32'd1 : cnt;
  assign put_way   = m.found ? WAY_BITS'(m.found_way) : victim;

  always_comb begin
    new_row = rd_row;
    new_row[put_way] = '{valid: 1'b1, tag: key_q, payload: payload_q};
  end

  assign ram_wr_addr = (state == sadrt_pkg::ST_SWEEP) ? sweep_idx : key_q[SET_BITS-1:0];
  assign ram_wr_data = (state == sadrt_pkg::ST_SWEEP) ? '0 : ROW_W'(new_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sadrt_pkg::ST_SWEEP;
      sweep_idx <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == sadrt_pkg::ST_SWEEP) begin
        sweep_idx <= sweep_idx + 1'b1;
      end
      if (go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_rd_en) begin
      mode_q    <= mode;
      key_q     <= position_key;
      payload_q <= '{move: move_in, kind: node_kind_in, depth: depth_in, score: score_in};
    end
    if (go) begin
      hit             <= hit_next;
      score_out       <= data_next.score;
      depth_out       <= data_next.depth;
      move_out        <= data_next.move;
      node_kind_out   <= data_next.kind;
      evicted_random  <= evict;
      overwrite_total <= cnt_next;
    end
  end

  `SADRT_ASSERT_NEXT(a_accept_to_look, in_valid && in_ready, state == sadrt_pkg::ST_LOOK,
    "accepted item did not move to the compare cycle")
  `SADRT_ASSERT_SAME(a_no_write_idle, ram_wr_en, state != sadrt_pkg::ST_IDLE,
    "row write while idle")
  `SADRT_ASSERT_NEXT(a_evict_count, evict, overwrite_total == $past(cnt) + 32'd1,
    "replacement count did not advance with an eviction")
  `SADRT_ASSERT_SAME(a_hit_not_evict, out_valid, !(hit && evicted_random),
    "result shows both a hit and an eviction")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the set-associative position cache.
// Depends on sadrt_pkg and set_associative_depth_replace_table; a scoreboard class
// tracks the table contents and predicts every result from the accepted commands.
module testbench;
  import sadrt_pkg::*;

  localparam int SET_BITS = DEF_SET_BITS;
  localparam int WAYS = DEF_WAYS;
  localparam int SLOTS = (1 << SET_BITS) * WAYS;
  localparam int RANDOM_CMDS = 600;

  typedef struct packed {
    logic [1:0]         mode;
    logic [63:0]        key;
    logic signed [31:0] score;
    logic [7:0]         depth;
    logic [15:0]        move;
    logic [1:0]         kind;
  } cache_cmd_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] score;
    logic [7:0]         depth;
    logic [15:0]        move;
    logic [1:0]         kind;
    logic               evicted;
    logic [31:0]        total;
  } cache_reply_t;

  class table_scoreboard;
    bit          live [SLOTS];
    logic [63:0] tags [SLOTS];
    payload_t    entries [SLOTS];
    logic [15:0] victim_state;
    logic [31:0] replaced;
    cache_reply_t awaited [$];
    int errors;
    int checked;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      victim_state = LFSR_SEED;
      replaced = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void fill_way(int slot, logic [63:0] key, payload_t data);
      live[slot] = 1'b1;
      tags[slot] = key;
      entries[slot] = data;
    endfunction

    function void note_transfer(cache_cmd_t c);
      cache_reply_t r;
      payload_t fresh;
      int base;
      bit placed;
      r = '0;
      base = int'(c.key[SET_BITS-1:0]) * WAYS;
      fresh.move = c.move;
      fresh.kind = c.kind;
      fresh.depth = c.depth;
      fresh.score = c.score;
      placed = 1'b0;
      case (c.mode)
        MODE_PROBE: begin
          for (int w = 0; w < WAYS; w++) begin
            if (live[base+w] && tags[base+w] == c.key) begin
              r.hit = 1'b1;
              r.score = entries[base+w].score;
              r.depth = entries[base+w].depth;
              r.move = entries[base+w].move;
              r.kind = entries[base+w].kind;
              break;
            end
          end
        end
        MODE_SAVE: begin
          for (int w = 0; w < WAYS; w++) begin
            if (!live[base+w]) begin
              fill_way(base + w, c.key, fresh);
              placed = 1'b1;
              break;
            end else if (tags[base+w] == c.key) begin
              if (entries[base+w].depth < c.depth) fill_way(base + w, c.key, fresh);
              placed = 1'b1;
              break;
            end
          end
          if (!placed) begin
            victim_state = (victim_state >> 1) ^ (victim_state[0] ? LFSR_TAPS : 16'h0000);
            replaced = replaced + 32'd1;
            fill_way(base + int'(victim_state % WAYS), c.key, fresh);
            r.evicted = 1'b1;
          end
        end
        MODE_CLEAR: begin
          foreach (live[i]) live[i] = 1'b0;
        end
        default: begin
        end
      endcase
      r.total = replaced;
      awaited.push_back(r);
    endfunction

    function string describe(cache_reply_t r);
      return $sformatf("hit=%0d score=%0d depth=%0d move=%h kind=%0d evicted=%0d total=%0d",
                       r.hit, r.score, r.depth, r.move, r.kind, r.evicted, r.total);
    endfunction

    function void check_result(cache_reply_t got);
      cache_reply_t want;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Result %0d arrived with none pending: %s", checked,
                                   describe(got));
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("Result %0d mismatch", checked);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         mode;
  logic [63:0]        position_key;
  logic signed [31:0] score_in;
  logic [7:0]         depth_in;
  logic [15:0]        move_in;
  logic [1:0]         node_kind_in;
  logic               out_valid;
  logic               out_ready;
  logic               hit;
  logic signed [31:0] score_out;
  logic [7:0]         depth_out;
  logic [15:0]        move_out;
  logic [1:0]         node_kind_out;
  logic               evicted_random;
  logic [31:0]        overwrite_total;

  table_scoreboard book = new();
  logic [SET_BITS-1:0] hot_sets [6];
  logic [63-SET_BITS:0] hot_tags [6];
  bit held_once = 1'b0;

  set_associative_depth_replace_table #(
    .SET_BITS(SET_BITS),
    .WAYS(WAYS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .position_key(position_key),
    .score_in(score_in),
    .depth_in(depth_in),
    .move_in(move_in),
    .node_kind_in(node_kind_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit(hit),
    .score_out(score_out),
    .depth_out(depth_out),
    .move_out(move_out),
    .node_kind_out(node_kind_out),
    .evicted_random(evicted_random),
    .overwrite_total(overwrite_total)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 9) < 7)
      return {hot_tags[$urandom_range(0, 5)], hot_sets[$urandom_range(0, 5)]};
    return {$urandom, $urandom};
  endfunction

  function automatic cache_cmd_t make_cmd(logic [1:0] m, logic [63:0] k, logic signed [31:0] s,
                                          logic [7:0] d, logic [15:0] mv, logic [1:0] nk);
    cache_cmd_t c;
    c.mode = m;
    c.key = k;
    c.score = s;
    c.depth = d;
    c.move = mv;
    c.kind = nk;
    return c;
  endfunction

  function automatic cache_cmd_t random_cmd(logic [1:0] m);
    logic [7:0] d;
    d = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    return make_cmd(m, pick_key(), $urandom, d, 16'($urandom), 2'($urandom));
  endfunction

  // Offers one command, waits for its transfer, then idles for the given gap.
  task automatic transfer_cmd(cache_cmd_t c, int gap);
    mode <= c.mode;
    position_key <= c.key;
    score_in <= c.score;
    depth_in <= c.depth;
    move_in <= c.move;
    node_kind_in <= c.kind;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_transfer(c);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.awaited.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      book.check_result({hit, score_out, depth_out, move_out, node_kind_out,
                         evicted_random, overwrite_total});
    end
  end

  initial begin
    forever begin
      if (!held_once && book.checked >= 150) begin
        held_once = 1'b1;
        out_ready <= 1'b0;
        repeat (250) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 6))
          @(posedge clk);
        if (pick_gap() > 0) begin
          out_ready <= 1'b0;
          repeat (pick_gap() + 1) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #12_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [63:0] k;
    logic [1:0] m;
    int r;
    rst <= 1'b1;
    in_valid <= 1'b0;
    mode <= MODE_NOP;
    position_key <= '0;
    score_in <= '0;
    depth_in <= '0;
    move_in <= '0;
    node_kind_in <= '0;
    hot_sets = '{12'd0, 12'hFFF, 12'd5, 12'd1234, 12'd2048, 12'd7};
    hot_tags[0] = '0;
    hot_tags[1] = '1;
    for (int i = 2; i < 6; i++) hot_tags[i] = (64 - SET_BITS)'({$urandom, $urandom});
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed commands: empty probe, depth rules, a full set, no-op and clear.
    transfer_cmd(make_cmd(MODE_PROBE, 64'd0, 32'sd0, 8'd0, 16'd0, 2'd0), pick_gap());
    transfer_cmd(make_cmd(MODE_SAVE, 64'd0, 32'h7FFF_FFFF, 8'd0, 16'hFFFF, 2'd3), pick_gap());
    transfer_cmd(make_cmd(MODE_PROBE, 64'd0, 32'sd0, 8'd0, 16'd0, 2'd0), pick_gap());
    transfer_cmd(make_cmd(MODE_SAVE, 64'd0, 32'h8000_0000, 8'd0, 16'd0, 2'd0), pick_gap());
    transfer_cmd(make_cmd(MODE_SAVE, 64'd0, 32'h8000_0000, 8'd255, 16'd0, 2'd0), pick_gap());
    transfer_cmd(make_cmd(MODE_SAVE, 64'd0, 32'sd77, 8'd100, 16'h1234, 2'd2), pick_gap());
    transfer_cmd(make_cmd(MODE_PROBE, 64'd0, 32'sd0, 8'd0, 16'd0, 2'd0), pick_gap());
    transfer_cmd(make_cmd(MODE_SAVE, '1, 32'h7FFF_FFFF, 8'd255, 16'hFFFF, 2'd1), pick_gap());
    transfer_cmd(make_cmd(MODE_PROBE, '1, '1, '1, '1, '1), pick_gap());
    for (int i = 0; i < 6; i++) begin
      k = {52'(i * 977 + 1), 12'd5};
      transfer_cmd(make_cmd(MODE_SAVE, k, $urandom, 8'(i), 16'(i), 2'(i)), pick_gap());
    end
    transfer_cmd(make_cmd(MODE_PROBE, {52'd1, 12'd5}, '0, '0, '0, '0), pick_gap());
    transfer_cmd(make_cmd(MODE_PROBE, {52'd4886, 12'd5}, '0, '0, '0, '0), pick_gap());
    transfer_cmd(make_cmd(MODE_NOP, {$urandom, $urandom}, $urandom, '1, '1, '1), pick_gap());
    transfer_cmd(make_cmd(MODE_CLEAR, '1, '1, '1, '1, '1), pick_gap());
    transfer_cmd(make_cmd(MODE_PROBE, 64'd0, '0, '0, '0, '0), pick_gap());
    transfer_cmd(make_cmd(MODE_PROBE, '1, '0, '0, '0, '0), pick_gap());
    transfer_cmd(make_cmd(MODE_SAVE, 64'd0, -32'sd5, 8'd9, 16'hA5A5, 2'd1), pick_gap());
    transfer_cmd(make_cmd(MODE_PROBE, 64'd0, '0, '0, '0, '0), pick_gap());
    wait_drained();

    // Random commands concentrated on a few hot sets so that ways match and fill up.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) m = MODE_PROBE;
      else if (r < 93) m = MODE_SAVE;
      else m = MODE_NOP;
      if (n % 150 == 75) m = MODE_CLEAR;
      if (n == 300) wait_drained();
      transfer_cmd(random_cmd(m), (n >= 400 && n < 460) ? 0 : pick_gap());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (book.errors == 0 && book.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/sadrt_pkg.sv
sv/sadrt_ram.sv
sv/sadrt_match.sv
sv/sadrt_victim.sv
sv/set_associative_depth_replace_table.sv
verif/testbench.sv
